/* rtl/assert_macros.svh */
// Assertion macros shared by the trajectory unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clk_i edge while rst_ni is high.
`define ASSERT_P(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_P_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_P(lbl, prop, msg)
`define ASSERT_P_NR(lbl, prop, msg)

`endif

`endif

/* rtl/qwt_pkg.sv */
// Package with widths, codes, defaults and payload types of the trajectory unit.
`timescale 1ns / 1ps

package qwt_pkg;

  localparam int POS_W      = 24;
  localparam int TICKS_W    = 24;
  localparam int COUNT_W    = 3;
  localparam int SLOT_W     = 3;
  localparam int STEP_W     = 8;
  localparam int TIME_W     = 32;
  localparam int JOINT_MAX  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_WAYPOINTS_DEF = 8;
  localparam int JOINT_COUNT_DEF   = 7;
  localparam int PHASE_BITS_DEF    = 24;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 24'd2500;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

  // Quintic blend coefficients: 10 s^3 - 15 s^4 + 6 s^5
  localparam int BLEND_C3 = 10;
  localparam int BLEND_C4 = 15;
  localparam int BLEND_C5 = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'd1;

  typedef struct packed {
    logic                     command;
    logic [SLOT_W-1:0]        waypoint_slot;
    logic [SLOT_W-1:0]        joint_slot;
    logic signed [POS_W-1:0]  joint_value;
    logic [STEP_W-1:0]        elapsed_ticks;
  } req_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  joint_pos_0;
    logic signed [POS_W-1:0]  joint_pos_1;
    logic signed [POS_W-1:0]  joint_pos_2;
    logic signed [POS_W-1:0]  joint_pos_3;
    logic signed [POS_W-1:0]  joint_pos_4;
    logic signed [POS_W-1:0]  joint_pos_5;
    logic signed [POS_W-1:0]  joint_pos_6;
    logic [COUNT_W-1:0]       segment_now;
    logic                     finished;
  } rsp_t;

endpackage

/* rtl/qwt_stream_if.sv */
// Valid/ready request channel carrying one payload type.
`timescale 1ns / 1ps

interface qwt_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

/* rtl/quintic_waypoint_trajectory_unit.sv */
// Top level of the multi-joint quintic waypoint trajectory unit.
//
// Load requests write one joint position into the waypoint table. Tick
// requests add elapsed time, advance the segment at most once, and return one
// response with every joint position on the quintic blend of the current
// segment, the segment index and the finished flag. A tick skips the
// bit-serial phase divider (one quotient bit per cycle) when the phase sits at
// 0 or 1; the single shared multiplier serves the segment products, the phase
// powers and the per-joint scaling. The request side is not ready while a
// tick is in flight; a finished response waits in the output register while
// the next request is taken, and a tick ends only once that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quintic_waypoint_trajectory_unit #(
  parameter int MAX_WAYPOINTS       = qwt_pkg::MAX_WAYPOINTS_DEF,
  parameter int JOINT_COUNT         = qwt_pkg::JOINT_COUNT_DEF,
  parameter int PHASE_FRACTION_BITS = qwt_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qwt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  qwt_stream_if.sink                    req_i,
  qwt_stream_if.source                  rsp_o
);

  import qwt_pkg::*;

  localparam int F         = PHASE_FRACTION_BITS;
  localparam int MA        = (F + 2 > POS_W + 1) ? F + 2 : POS_W + 1;
  localparam int TW        = TIME_W + 2;
  localparam int BW        = F + 6;
  localparam int TBL_DEPTH = MAX_WAYPOINTS * JOINT_COUNT;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int JW        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int CW        = $clog2(F);
  localparam int MAX_SEG   = MAX_WAYPOINTS - 1;

  localparam logic [F:0] PHASE_ONE = {1'b1, {F{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV_MUL,
    ST_ADV,
    ST_USED_MUL,
    ST_TOT_MUL,
    ST_CHECK,
    ST_DIV,
    ST_POW,
    ST_BLEND,
    ST_JRD,
    ST_JDIF,
    ST_JMUL,
    ST_JADD,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [TICKS_W-1:0]      seg_ticks_q;
  logic [COUNT_W-1:0]      seg_count_q;
  logic [TIME_W-1:0]       elapsed_q;
  logic [COUNT_W-1:0]      cur_q;
  logic signed [2*MA-1:0]  prod_q;
  logic signed [TW-1:0]    t_q;
  logic                    fin_q;
  logic [TICKS_W-1:0]      rem_q;
  logic [F-1:0]            s_q;
  logic [CW-1:0]           div_cnt_q;
  logic [1:0]              pow_idx_q;
  logic [F-1:0]            acc_q;
  logic [F-1:0]            s3_q;
  logic [F-1:0]            s4_q;
  logic [F:0]              b_q;
  logic [JW-1:0]           j_q;
  logic signed [POS_W:0]   diff_q;
  logic signed [POS_W-1:0] start_q;
  logic signed [POS_W-1:0] pos_q [JOINT_COUNT];
  logic                    rsp_valid_q;
  rsp_t                    rsp_q;

  logic signed [POS_W-1:0] tbl_mem [TBL_DEPTH];
  logic signed [POS_W-1:0] rd_a_q;
  logic signed [POS_W-1:0] rd_b_q;

  logic [TICKS_W-1:0]      ticks_eff;
  logic [COUNT_W-1:0]      count_raw;
  logic [COUNT_W-1:0]      count_eff;
  logic [COUNT_W-1:0]      used;
  logic                    req_fire;
  logic                    tbl_we;
  logic [AW-1:0]           tbl_wa;
  logic [AW-1:0]           rd_addr_a;
  logic [AW-1:0]           rd_addr_b;
  logic [TIME_W:0]         elapsed_sum;
  logic signed [TW-1:0]    t_adv;
  logic signed [TW-1:0]    t_d;
  logic                    adv_ok;
  logic [TICKS_W:0]        rem2;
  logic                    div_ge;
  logic [TICKS_W:0]        rem_d;
  logic [F-1:0]            s_d;
  logic signed [MA-1:0]    op_a;
  logic signed [MA-1:0]    op_b;
  logic signed [2*MA-1:0]  mul_p;
  logic [F-1:0]            acc_d;
  logic signed [BW-1:0]    s3x;
  logic signed [BW-1:0]    s4x;
  logic signed [BW-1:0]    s5x;
  logic signed [BW-1:0]    bsum_d;
  logic [F:0]              b_d;
  logic signed [POS_W:0]   diff_d;
  logic signed [POS_W-1:0] pos_d;
  logic                    rsp_free;
  logic signed [POS_W-1:0] pos_full [JOINT_MAX];

  // Effective configuration
  assign ticks_eff = (seg_ticks_q == '0) ? TICKS_W'(1) : seg_ticks_q;
  assign count_raw = (seg_count_q == '0) ? COUNT_W'(1) : seg_count_q;
  assign count_eff = (32'(count_raw) > MAX_SEG) ? COUNT_W'(MAX_SEG) : count_raw;
  assign used      = (cur_q < count_eff) ? cur_q : count_eff - COUNT_W'(1);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign tbl_we = req_fire && (req_i.payload.command == CMD_LOAD)
                  && (32'(req_i.payload.waypoint_slot) < MAX_WAYPOINTS)
                  && (32'(req_i.payload.joint_slot) < JOINT_COUNT);
  assign tbl_wa = AW'(req_i.payload.waypoint_slot) * AW'(JOINT_COUNT)
                  + AW'(req_i.payload.joint_slot);

  assign rd_addr_a = AW'(used) * AW'(JOINT_COUNT) + AW'(j_q);
  assign rd_addr_b = rd_addr_a + AW'(JOINT_COUNT);

  assign elapsed_sum = {1'b0, elapsed_q} + (TIME_W + 1)'(req_i.payload.elapsed_ticks);

  assign t_adv  = $signed({2'b00, elapsed_q}) - TW'(prod_q);
  assign adv_ok = !t_adv[TW-1] && (t_adv[TW-2:0] > (TW - 1)'(ticks_eff))
                  && (({1'b0, cur_q} + 4'd1) < {1'b0, count_eff});

  assign t_d = $signed({2'b00, elapsed_q}) - TW'(prod_q);

  // Restoring division step
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, ticks_eff};
  assign rem_d  = div_ge ? rem2 - {1'b0, ticks_eff} : rem2;
  assign s_d    = {s_q[F-2:0], div_ge};

  // Shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ST_ADV_MUL: begin
        op_a = MA'(ticks_eff);
        op_b = MA'(cur_q);
      end
      ST_USED_MUL: begin
        op_a = MA'(ticks_eff);
        op_b = MA'(used);
      end
      ST_TOT_MUL: begin
        op_a = MA'(ticks_eff);
        op_b = MA'(count_eff);
      end
      ST_POW: begin
        op_a = MA'(acc_q);
        op_b = MA'(s_q);
      end
      ST_JMUL: begin
        op_a = MA'(diff_q);
        op_b = MA'(b_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_p = op_a * op_b;
  assign acc_d = mul_p[F +: F];

  // Blend polynomial with clamp to 0..one
  assign s3x    = $signed(BW'(s3_q));
  assign s4x    = $signed(BW'(s4_q));
  assign s5x    = $signed(BW'(acc_q));
  assign bsum_d = BW'(s3x * BLEND_C3) - BW'(s4x * BLEND_C4) + BW'(s5x * BLEND_C5);

  always_comb begin
    if (bsum_d[BW-1]) begin
      b_d = '0;
    end else if (bsum_d[BW-2:0] > (BW - 1)'(PHASE_ONE)) begin
      b_d = PHASE_ONE;
    end else begin
      b_d = bsum_d[F:0];
    end
  end

  assign diff_d = $signed({rd_b_q[POS_W-1], rd_b_q}) - $signed({rd_a_q[POS_W-1], rd_a_q});
  assign pos_d  = start_q + prod_q[F +: POS_W];

  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  for (genvar k = 0; k < JOINT_MAX; k++) begin : g_pos
    if (k < JOINT_COUNT) begin : g_used
      assign pos_full[k] = pos_q[k];
    end else begin : g_zero
      assign pos_full[k] = '0;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Waypoint table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= req_i.payload.joint_value;
    end
    if (state_q == ST_JRD) begin
      rd_a_q <= tbl_mem[rd_addr_a];
      rd_b_q <= tbl_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_ticks_q <= TICKS_RESET;
      seg_count_q <= COUNT_RESET;
      elapsed_q   <= '0;
      cur_q       <= '0;
      prod_q      <= '0;
      t_q         <= '0;
      fin_q       <= 1'b0;
      rem_q       <= '0;
      s_q         <= '0;
      div_cnt_q   <= '0;
      pow_idx_q   <= '0;
      acc_q       <= '0;
      s3_q        <= '0;
      s4_q        <= '0;
      b_q         <= '0;
      j_q         <= '0;
      diff_q      <= '0;
      start_q     <= '0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        pos_q[k] <= '0;
      end
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEG_TICKS: seg_ticks_q <= cfg_data_i[TICKS_W-1:0];
          CFG_SEG_COUNT: seg_count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      if ((state_q == ST_DONE) && rsp_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_fire && (req_i.payload.command == CMD_TICK)) begin
            elapsed_q <= elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
            state_q   <= ST_ADV_MUL;
          end
        end
        ST_ADV_MUL: begin
          prod_q  <= mul_p;
          state_q <= ST_ADV;
        end
        ST_ADV: begin
          if (adv_ok) begin
            cur_q <= cur_q + COUNT_W'(1);
          end
          state_q <= ST_USED_MUL;
        end
        ST_USED_MUL: begin
          prod_q  <= mul_p;
          state_q <= ST_TOT_MUL;
        end
        ST_TOT_MUL: begin
          t_q     <= t_d;
          prod_q  <= mul_p;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          fin_q <= {2'b00, elapsed_q} >= TW'(prod_q);
          j_q   <= '0;
          if (t_q[TW-1] || (t_q == '0)) begin
            b_q     <= '0;
            state_q <= ST_JRD;
          end else if (t_q[TW-2:0] >= (TW - 1)'(ticks_eff)) begin
            b_q     <= PHASE_ONE;
            state_q <= ST_JRD;
          end else begin
            rem_q     <= t_q[TICKS_W-1:0];
            s_q       <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q     <= rem_d[TICKS_W-1:0];
          s_q       <= s_d;
          div_cnt_q <= div_cnt_q + CW'(1);
          if (div_cnt_q == CW'(F - 1)) begin
            acc_q     <= s_d;
            pow_idx_q <= '0;
            state_q   <= ST_POW;
          end
        end
        ST_POW: begin
          acc_q     <= acc_d;
          pow_idx_q <= pow_idx_q + 2'd1;
          if (pow_idx_q == 2'd1) begin
            s3_q <= acc_d;
          end
          if (pow_idx_q == 2'd2) begin
            s4_q <= acc_d;
          end
          if (pow_idx_q == 2'd3) begin
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          b_q     <= b_d;
          state_q <= ST_JRD;
        end
        ST_JRD: begin
          state_q <= ST_JDIF;
        end
        ST_JDIF: begin
          diff_q  <= diff_d;
          start_q <= rd_a_q;
          state_q <= ST_JMUL;
        end
        ST_JMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_JADD;
        end
        ST_JADD: begin
          pos_q[j_q] <= pos_d;
          if (32'(j_q) == JOINT_COUNT - 1) begin
            state_q <= ST_DONE;
          end else begin
            j_q     <= j_q + JW'(1);
            state_q <= ST_JRD;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_q.joint_pos_0 <= pos_full[0];
            rsp_q.joint_pos_1 <= pos_full[1];
            rsp_q.joint_pos_2 <= pos_full[2];
            rsp_q.joint_pos_3 <= pos_full[3];
            rsp_q.joint_pos_4 <= pos_full[4];
            rsp_q.joint_pos_5 <= pos_full[5];
            rsp_q.joint_pos_6 <= pos_full[6];
            rsp_q.segment_now <= cur_q;
            rsp_q.finished    <= fin_q;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_P(a_seg_bound, 32'(cur_q) <= MAX_WAYPOINTS - 2, "segment index beyond last segment")
  `ASSERT_P(a_elapsed_mono, elapsed_q >= $past(elapsed_q), "elapsed time went backward")
  `ASSERT_P(a_div_rem, (state_q == ST_DIV) |-> (rem_q < ticks_eff), "divider remainder too large")
  `ASSERT_P(a_blend_max, (state_q == ST_JRD) |-> (b_q <= PHASE_ONE), "blend weight above one")

endmodule
